// ===== design/ivps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivps_pkg: shared types and constants for the interval predecessor search
// Beat formats, operation and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package ivps_pkg;

   // Default sizes of the start table and of a position
   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_POS_BITS    = 32;

   // Fixed field widths
   localparam int FIELD_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Request beat
   typedef struct packed {
      logic               op;
      logic               new_set;
      logic [FIELD_W-1:0] entry_start;
      logic [FIELD_W-1:0] query_position;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [INDEX_W-1:0]  interval_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic                do_load;
      logic                do_query_init;
      logic                do_probe;
      logic                do_compare;
      logic                rsp_fire;
      logic                rsp_use_lo;
      logic [STATUS_W-1:0] rsp_status;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic lo_eq_hi;
   } dp_status_type;

endpackage

// ===== design/ivps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivps_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ivps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ivps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivps_ctrl: sequencer for loads and binary-search queries
// Accepts a beat when idle, steps the search through probe and compare
// states, and tells the datapath when to emit the response.
// ----------------------------------------------------------------------------
module ivps_ctrl
   import ivps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_item,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CMP   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Decode state and status into commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.op == OP_LOAD) begin
                  cmd.do_load    = 1'b1;
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = (!req_item.new_set && dp_status.full) ? ST_FULL : ST_OK;
               end else if (dp_status.empty) begin
                  cmd.rsp_fire   = 1'b1;
                  cmd.rsp_status = ST_EMPTY;
               end else begin
                  cmd.do_query_init = 1'b1;
                  state_in          = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (dp_status.lo_eq_hi) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_use_lo = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.do_probe = 1'b1;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            cmd.do_compare = 1'b1;
            state_in       = S_PROBE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/ivps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivps_datapath: start table, entry count, search bounds and response
// Holds the table RAM and the lo/hi/mid registers of the upper-mid binary
// search, and registers the response beat.
// ----------------------------------------------------------------------------
module ivps_datapath
   import ivps_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int POS_BITS    = DEF_POS_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_item,
   input  ctrl_cmd_type  cmd,
   output dp_status_type dp_status,
   output logic          rsp_valid,
   output rsp_type       rsp_item
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = (POS_BITS < FIELD_W) ? POS_BITS : FIELD_W;

   logic [CNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]  lo_ff;
   logic [ADDR_W-1:0]  hi_ff;
   logic [ADDR_W-1:0]  mid_ff;
   logic [ENTRY_W-1:0] pos_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_item_ff;

   logic [ADDR_W:0]    bound_sum;
   logic [ADDR_W-1:0]  mid_in;
   logic               full;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] rd_data;

   assign full      = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_in    = bound_sum[ADDR_W:1] + ADDR_W'(1);

   assign dp_status.full     = full;
   assign dp_status.empty    = (count_ff == '0);
   assign dp_status.lo_eq_hi = (lo_ff == hi_ff);

   // Store at the fill point; a new set restarts at entry zero
   assign wr_en   = cmd.do_load && (req_item.new_set || !full);
   assign wr_addr = req_item.new_set ? '0 : count_ff[ADDR_W-1:0];

   ivps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_item.entry_start[ENTRY_W-1:0]),
      .rd_en   (cmd.do_probe),
      .rd_addr (mid_in),
      .rd_data (rd_data)
   );

   // Track the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_load) begin
         if (req_item.new_set) begin
            count_ff <= CNT_W'(1);
         end else if (!full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // Narrow the search bounds
   always_ff @(posedge clock) begin
      if (cmd.do_query_init) begin
         lo_ff  <= '0;
         hi_ff  <= ADDR_W'(count_ff - CNT_W'(1));
         pos_ff <= req_item.query_position[ENTRY_W-1:0];
      end else if (cmd.do_compare) begin
         if (rd_data > pos_ff) begin
            hi_ff <= mid_ff - ADDR_W'(1);
         end else begin
            lo_ff <= mid_ff;
         end
      end
      if (cmd.do_probe) begin
         mid_ff <= mid_in;
      end
   end

   // Register the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_item_ff.interval_index <= cmd.rsp_use_lo ? INDEX_W'(lo_ff) : '0;
         rsp_item_ff.status         <= cmd.rsp_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A compare always follows the read issued in the previous cycle
   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      cmd.do_compare |-> $past(cmd.do_probe))
      else $error("compare without a preceding probe");

   // A probe only happens while the interval is still open
   a_probe_open: assert property (@(posedge clock) disable iff (reset)
      cmd.do_probe |-> (lo_ff < hi_ff))
      else $error("probe on a closed interval");

   // The probed entry lies inside the loaded part of the table
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.do_compare |-> (CNT_W'(mid_ff) < count_ff))
      else $error("probe beyond the loaded entries");

   // The fill count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

// ===== design/interval_predecessor_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_predecessor_search: predecessor lookup over loaded start positions
// Loads start positions into a table and answers predecessor queries with an
// upper-mid binary search over the loaded entries.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low, and every beat gives
// exactly one response on rsp_item, marked by rsp_valid for one cycle; the
// response cannot be held off, so it must be captured in that cycle. A load,
// and a query on an empty table, keep busy low and answer in the next cycle.
// A query over n loaded entries runs k <= ceil(log2(n)) search steps and
// keeps busy high while it runs, with the response in the same cycle that busy
// drops. Each step passes through a probe state and a compare state, because
// the table RAM's registered read sits inside the search loop.
// Positions are compared in their low POS_BITS bits; the table needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module interval_predecessor_search
   import ivps_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int POS_BITS    = DEF_POS_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   ivps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ivps_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .POS_BITS    (POS_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/interval_predecessor_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_predecessor_search_test: self-checking bench for the predecessor search
// Builds start-position tables of many sizes and shapes, including one full
// table with overflow loads, and fires lookups at entries, their neighbors
// and the ends of the position range. Every response is checked against a
// mirror of the table searched with the same upper-mid bisection.
// ----------------------------------------------------------------------------
module interval_predecessor_search_test;
   import ivps_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 6;
   localparam int TARGET_BEATS  = 1850;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 30;
   localparam logic [FIELD_W-1:0] POS_MAX = {FIELD_W{1'b1}};

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Beats waiting to be driven, and responses waiting to be seen
   req_type pending_beats[$];
   rsp_type answer_fifo[$];

   // Mirror of the block's table
   logic [FIELD_W-1:0] start_mirror[DEF_TABLE_DEPTH];
   int unsigned        table_count = 0;

   int idle_left;
   int beats_taken     = 0;
   int loads_seen      = 0;
   int full_drops      = 0;
   int lookups_seen    = 0;
   int empty_lookups   = 0;
   int largest_table   = 0;
   int answers_checked = 0;
   int mismatches      = 0;
   int stray_answers   = 0;

   interval_predecessor_search u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Apply one beat to the mirror and return the response it must produce
   function automatic rsp_type predict_answer(req_type beat);
      rsp_type     ans;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      ans.interval_index = '0;
      ans.status         = ST_OK;
      if (beat.op == OP_LOAD) begin
         if (beat.new_set) table_count = 0;
         if (table_count >= DEF_TABLE_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            start_mirror[table_count] = beat.entry_start;
            table_count++;
         end
      end else if (table_count == 0) begin
         ans.status = ST_EMPTY;
      end else begin
         lo = 0;
         hi = table_count - 1;
         while (lo != hi) begin
            mid = (lo + hi) / 2 + 1;
            if (start_mirror[mid] > beat.query_position) hi = mid - 1;
            else lo = mid;
         end
         ans.interval_index = lo[INDEX_W-1:0];
      end
      return ans;
   endfunction

   // Gap before the next beat: runs with no gaps, otherwise mostly short
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if ((beats_taken % 300) < 60) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(3, 1);
      if (r < 96) return $urandom_range(25, 4);
      return $urandom_range(60, 26);
   endfunction

   // Queue a load; the unused position field gets random bits
   task automatic add_load(input logic new_set, input logic [FIELD_W-1:0] value);
      req_type beat;
      beat.op             = OP_LOAD;
      beat.new_set        = new_set;
      beat.entry_start    = value;
      beat.query_position = $urandom();
      pending_beats.push_back(beat);
   endtask

   // Queue a lookup; new_set and the entry field are don't-cares
   task automatic add_query(input logic [FIELD_W-1:0] pos);
      req_type beat;
      beat.op             = OP_QUERY;
      beat.new_set        = 1'($urandom_range(1, 0));
      beat.entry_start    = $urandom();
      beat.query_position = pos;
      pending_beats.push_back(beat);
   endtask

   // Pick a lookup position near the given set's entries, at random, or at the range ends
   function automatic logic [FIELD_W-1:0] pick_position(ref logic [FIELD_W-1:0] vals[$]);
      logic [FIELD_W-1:0] base;
      int                 r;
      base = vals[$urandom_range(vals.size() - 1, 0)];
      r    = $urandom_range(9, 0);
      case (r)
         0, 1, 2, 3: return base;
         4, 5:       return base + 1;
         6:          return base - 1;
         7:          return $urandom();
         8:          return '0;
         default:    return POS_MAX;
      endcase
   endfunction

   // Build one set: a new_set load, more loads with the odd lookup between
   // them, then a burst of lookups. Shapes: ascending, dense with repeats,
   // or unordered.
   task automatic add_set(input int size, input int shape, input int lookups);
      logic [FIELD_W-1:0] vals[$];
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] step_max;
      int                 i;
      value    = $urandom() >> $urandom_range(31, 0);
      step_max = (POS_MAX - value) / size;
      if (shape == 1 && step_max > 3) step_max = 3;
      for (i = 0; i < size; i++) begin
         if (shape == 2) value = $urandom();
         else if (i > 0) value = value + $urandom_range(step_max, 0);
         vals.push_back(value);
         add_load(i == 0, value);
         if (i > 0 && $urandom_range(9, 0) == 0) add_query(pick_position(vals));
      end
      for (i = 0; i < lookups; i++) add_query(pick_position(vals));
   endtask

   // Driver: hold a beat until taken, then predict it and move on
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         req_item  <= '0;
         idle_left <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            rsp_type ans;
            ans = predict_answer(req_item);
            answer_fifo.push_back(ans);
            beats_taken++;
            if (req_item.op == OP_LOAD) loads_seen++;
            else lookups_seen++;
            if (ans.status == ST_FULL) full_drops++;
            if (ans.status == ST_EMPTY) empty_lookups++;
            if (table_count > largest_table) largest_table = table_count;
         end
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_item  <= pending_beats.pop_front();
            start     <= 1'b1;
            idle_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (answer_fifo.size() == 0) begin
            stray_answers++;
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected response: index %0d status %0d",
                        $realtime, rsp_item.interval_index, rsp_item.status);
         end else begin
            rsp_type exp_ans;
            exp_ans = answer_fifo.pop_front();
            answers_checked++;
            if (rsp_item.interval_index !== exp_ans.interval_index ||
                rsp_item.status !== exp_ans.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] mismatch: expected index %0d status %0d, got index %0d status %0d",
                           $realtime, exp_ans.interval_index, exp_ans.status,
                           rsp_item.interval_index, rsp_item.status);
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) stalled = 0;
         else stalled++;
      end
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int shape;
      int size;
      int i;
      int total_beats;
      reset = 1'b1;

      // Lookups on the empty table, then a first load without new_set
      add_query('0);
      add_query(POS_MAX);
      add_load(1'b0, 32'd100);
      add_query(32'd99);
      add_query(32'd100);
      add_query(POS_MAX);
      // Extremes, a repeated entry, and lookups below, on and between them
      add_load(1'b1, '0);
      add_load(1'b0, 32'd10);
      add_load(1'b0, 32'd20);
      add_load(1'b0, 32'd20);
      add_load(1'b0, 32'd30);
      add_load(1'b0, POS_MAX);
      add_query('0);
      add_query(32'd9);
      add_query(32'd20);
      add_query(32'd25);
      add_query(POS_MAX - 1);
      add_query(POS_MAX);
      // Entries out of order, and a start above every lookup
      add_load(1'b1, 32'd50);
      add_load(1'b0, 32'd40);
      add_load(1'b0, 32'd60);
      add_load(1'b0, 32'd10);
      add_query(32'd45);
      add_query(32'd5);

      // Fill the whole table, push past the end, then search it
      add_set(DEF_TABLE_DEPTH, 0, 0);
      for (i = 0; i < 3; i++) add_load(1'b0, $urandom());
      for (i = 0; i < 12; i++) add_query($urandom());
      add_query('0);
      add_query(POS_MAX);

      // Random sets, mostly small
      while (pending_beats.size() < TARGET_BEATS) begin
         size  = $urandom_range(99, 0);
         if (size < 70) size = $urandom_range(8, 1);
         else if (size < 95) size = $urandom_range(64, 9);
         else size = $urandom_range(300, 65);
         shape = $urandom_range(9, 0);
         if (shape < 7) shape = 0;
         else if (shape < 9) shape = 1;
         else shape = 2;
         add_set(size, shape, $urandom_range(10, 1));
      end
      total_beats = pending_beats.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait until every beat is taken and every response is seen
      while (beats_taken < total_beats) @(posedge clock);
      while (answer_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d loads (%0d dropped on a full table) and %0d lookups (%0d empty)",
               loads_seen, full_drops, lookups_seen, empty_lookups);
      $display("Checked %0d responses, largest table %0d entries, %0d mismatches",
               answers_checked, largest_table, mismatches);
      if (mismatches == 0 && stray_answers == 0 && answer_fifo.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
